@@ sv/fbpm_pkg.sv @@
// Shared types, widths and codes for the frame buffer pool manager.
// Used by the controller, the datapath and the top level; depends on nothing.
package fbpm_pkg;

  // Field widths fixed by the interface
  localparam int IDX_W  = 4;
  localparam int CNT_W  = 5;
  localparam int OP_W   = 2;
  localparam int ST_W   = 3;
  localparam int DROP_W = 32;

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_POOL_COUNT   = 1'b0;
  localparam logic REG_POOL_ENABLED = 1'b1;

  // Defaults
  localparam int POOL_MAX_DEFAULT = 16;
  localparam int POOL_COUNT_RESET = 4;

  typedef enum logic [OP_W-1:0] {
    OP_ACQUIRE = 2'd0,
    OP_SUBMIT  = 2'd1,
    OP_CONSUME = 2'd2,
    OP_RELEASE = 2'd3
  } opcode_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_INIT  = 3'd1,
    ST_INVALID   = 3'd2,
    ST_EXHAUSTED = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  // Which pending slot a read targets
  typedef enum logic [1:0] {
    RD_HEAD  = 2'd0,
    RD_LAST  = 2'd1,
    RD_DRAIN = 2'd2
  } pend_rd_mode_t;

  // Controller to datapath commands
  typedef struct packed {
    logic          latch;
    logic          free_rd;
    logic          free_pop;
    logic          pend_rd;
    pend_rd_mode_t pend_mode;
    logic          pend_pop;
    logic          grant_cons;
    logic          drain_rd;
    logic          drain_push;
    logic          pend_clear;
    logic          pend_push;
    logic          free_push_idx;
    logic          load_out;
    status_t       status;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    opcode_t op;
    logic    free_empty;
    logic    pend_empty;
    logic    submit_bad;
    logic    release_bad;
    logic    k_done;
  } dp_stat_t;

  // Pool count clamped to 1..pmax
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] pc, input int pmax);
    logic [CNT_W-1:0] c;
    c = pc;
    if (c == '0) begin
      c = CNT_W'(1);
    end else if (int'(c) > pmax) begin
      c = CNT_W'(pmax);
    end
    return c;
  endfunction

endpackage

@@ sv/frame_buffer_pool_manager.sv @@
// Top level of the frame buffer pool manager: configuration registers and
// the controller/datapath pair. Depends on fbpm_pkg, fbpm_ctrl, fbpm_datapath.
//
// Hands out frame buffer indices from a pool of pool_count buffers using a
// free FIFO and a pending FIFO, dropping the oldest pending frame when the
// free FIFO runs dry. One item is in work at a time, and each gives one
// result beat. Submit, release, errors and disabled operations go from
// decode straight to the result; acquire first reads and pops the free
// FIFO, or the pending FIFO when the free FIFO is empty; consume latest
// reads and grants the newest pending frame, then drops the older pending
// frames (up to POOL_MAX - 1), returning each to the free FIFO where it
// fits and moving one entry per cycle through the single read port of the
// pending RAM. A new item is taken once the result is loaded, also while
// the previous result beat still waits in the output register. Any write
// to pool_count or pool_enabled rebuilds both FIFOs in the same cycle (no
// clearing pass) and keeps the drop counter.
module frame_buffer_pool_manager import fbpm_pkg::*; #(
  parameter int POOL_MAX = POOL_MAX_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // Operation channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [OP_W-1:0]       opcode,
  input  logic [IDX_W-1:0]      buffer_index,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ST_W-1:0]       status,
  output logic [IDX_W-1:0]      granted_index,
  output logic [CNT_W-1:0]      free_count,
  output logic [DROP_W-1:0]     dropped_total
);

  logic             pool_enabled;
  logic [CNT_W-1:0] pool_count;
  logic [CNT_W-1:0] init_count;
  logic             cfg_wr;
  cmd_t             cmd;
  dp_stat_t         dp_stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Count that takes effect with this write
  assign init_count = (cfg_wr && (paddr[2] == REG_POOL_COUNT)) ? pwdata[CNT_W-1:0] : pool_count;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_count   <= CNT_W'(POOL_COUNT_RESET);
      pool_enabled <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_POOL_COUNT:   pool_count   <= pwdata[CNT_W-1:0];
        REG_POOL_ENABLED: pool_enabled <= pwdata[0];
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (paddr[2])
      REG_POOL_COUNT:   prdata = APB_DATA_W'(pool_count);
      REG_POOL_ENABLED: prdata = APB_DATA_W'(pool_enabled);
    endcase
  end

  fbpm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .enabled   (pool_enabled),
    .dp_stat   (dp_stat),
    .cmd       (cmd)
  );

  fbpm_datapath #(.POOL_MAX(POOL_MAX)) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .reinit        (cfg_wr),
    .init_count    (init_count),
    .pool_count    (pool_count),
    .in_opcode     (opcode),
    .in_index      (buffer_index),
    .cmd           (cmd),
    .dp_stat       (dp_stat),
    .status        (status),
    .granted_index (granted_index),
    .free_count    (free_count),
    .dropped_total (dropped_total)
  );

endmodule

@@ sv/fbpm_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// Stand-alone; no package needed.
module fbpm_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read beat
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/fbpm_ctrl.sv @@
// Sequencing state machine of the frame buffer pool manager.
// Depends on fbpm_pkg; drives the datapath through cmd_t and reads dp_stat_t.
module fbpm_ctrl import fbpm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  logic     enabled,
  input  dp_stat_t dp_stat,
  output cmd_t     cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_READ   = 6'b000100,
    S_GRANT  = 6'b001000,
    S_DRAIN  = 6'b010000,
    S_RESULT = 6'b100000
  } state_t;

  state_t  state, state_next;
  status_t status_q, status_q_next;
  logic    drain_rd_q, drain_rd_q_next;

  assign in_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    cmd             = '0;
    cmd.status      = status_q;
    state_next      = state;
    status_q_next   = status_q;
    drain_rd_q_next = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        status_q_next = ST_OK;
        state_next    = S_RESULT;
        if (!enabled) begin
          status_q_next = ST_NOT_INIT;
        end else begin
          unique case (dp_stat.op)
            OP_ACQUIRE: begin
              if (!dp_stat.free_empty) begin
                cmd.free_rd = 1'b1;
                state_next  = S_READ;
              end else if (!dp_stat.pend_empty) begin
                cmd.pend_rd   = 1'b1;
                cmd.pend_mode = RD_HEAD;
                state_next    = S_READ;
              end else begin
                status_q_next = ST_EXHAUSTED;
              end
            end
            OP_SUBMIT: begin
              if (dp_stat.submit_bad) begin
                status_q_next = ST_INVALID;
              end else begin
                cmd.pend_push = 1'b1;
              end
            end
            OP_CONSUME: begin
              if (dp_stat.pend_empty) begin
                status_q_next = ST_NOT_FOUND;
              end else begin
                cmd.pend_rd   = 1'b1;
                cmd.pend_mode = RD_LAST;
                state_next    = S_GRANT;
              end
            end
            OP_RELEASE: begin
              if (dp_stat.release_bad) begin
                status_q_next = ST_INVALID;
              end else begin
                cmd.free_push_idx = 1'b1;
              end
            end
          endcase
        end
      end
      S_READ: begin
        // Free FIFO is untouched since decode, so it tells which pop was issued
        if (!dp_stat.free_empty) begin
          cmd.free_pop = 1'b1;
        end else begin
          cmd.pend_pop = 1'b1;
        end
        state_next = S_RESULT;
      end
      S_GRANT: begin
        cmd.grant_cons = 1'b1;
        state_next     = S_DRAIN;
      end
      S_DRAIN: begin
        // Read one older entry per cycle, push it the cycle after
        cmd.drain_rd    = !dp_stat.k_done;
        cmd.pend_rd     = !dp_stat.k_done;
        cmd.pend_mode   = RD_DRAIN;
        cmd.drain_push  = drain_rd_q;
        drain_rd_q_next = !dp_stat.k_done;
        if (dp_stat.k_done && !drain_rd_q) begin
          cmd.pend_clear = 1'b1;
          state_next     = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      status_q   <= ST_OK;
      drain_rd_q <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      status_q   <= status_q_next;
      drain_rd_q <= drain_rd_q_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ sv/fbpm_datapath.sv @@
// Datapath of the frame buffer pool manager: FIFO pointers, both queue RAMs,
// drop counter and result register. Depends on fbpm_pkg and fbpm_ram.
module fbpm_datapath import fbpm_pkg::*; #(
  parameter int POOL_MAX = POOL_MAX_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              reinit,
  input  logic [CNT_W-1:0]  init_count,
  input  logic [CNT_W-1:0]  pool_count,
  input  logic [OP_W-1:0]   in_opcode,
  input  logic [IDX_W-1:0]  in_index,
  input  cmd_t              cmd,
  output dp_stat_t          dp_stat,
  output logic [ST_W-1:0]   status,
  output logic [IDX_W-1:0]  granted_index,
  output logic [CNT_W-1:0]  free_count,
  output logic [DROP_W-1:0] dropped_total
);

  localparam int PTR_W = POOL_MAX > 1 ? $clog2(POOL_MAX) : 1;
  localparam int SUM_W = (PTR_W > CNT_W ? PTR_W : CNT_W) + 1;

  // Ring slot head+k, with head+k always below twice the depth
  function automatic logic [PTR_W-1:0] slot(input logic [PTR_W-1:0] head,
                                            input logic [CNT_W-1:0] k);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(k);
    if (sum >= SUM_W'(POOL_MAX)) begin
      sum = sum - SUM_W'(POOL_MAX);
    end
    return sum[PTR_W-1:0];
  endfunction

  opcode_t           op_q;
  logic [IDX_W-1:0]  idx_q;
  logic [PTR_W-1:0]  free_head, pend_head;
  logic [CNT_W-1:0]  free_occ, pend_occ, k;
  logic [DROP_W-1:0] drop_cnt;
  logic [IDX_W-1:0]  granted;
  logic              free_valid [POOL_MAX];
  logic              free_rd_valid;
  logic [IDX_W-1:0]  free_rd_dflt;
  logic [CNT_W-1:0]  n;

  logic              free_we;
  logic [PTR_W-1:0]  free_waddr;
  logic [IDX_W-1:0]  free_wdata;
  logic [IDX_W-1:0]  free_q, free_data;
  logic [PTR_W-1:0]  pend_waddr, pend_raddr;
  logic [IDX_W-1:0]  pend_q;
  logic              drain_fits;
  logic [DROP_W-1:0] drop_inc;

  assign n          = eff_count(pool_count, POOL_MAX);
  assign drain_fits = (free_occ < n);
  assign drop_inc   = (drop_cnt == '1) ? drop_cnt : drop_cnt + DROP_W'(1);

  // Status toward the controller
  assign dp_stat.op          = op_q;
  assign dp_stat.free_empty  = (free_occ == '0);
  assign dp_stat.pend_empty  = (pend_occ == '0);
  assign dp_stat.submit_bad  = (CNT_W'(idx_q) >= n) || (pend_occ >= n);
  assign dp_stat.release_bad = (CNT_W'(idx_q) >= n) || (free_occ >= n);
  assign dp_stat.k_done      = (k == pend_occ - CNT_W'(1));

  // Free FIFO write port: release or drained pending entry
  assign free_we    = cmd.free_push_idx || (cmd.drain_push && drain_fits);
  assign free_waddr = slot(free_head, free_occ);
  assign free_wdata = cmd.drain_push ? pend_q : idx_q;

  // Slots never written since reinit hold their own index
  assign free_data = free_rd_valid ? free_q : free_rd_dflt;

  fbpm_ram #(.WIDTH(IDX_W), .DEPTH(POOL_MAX)) u_free_ram (
    .clk   (clk),
    .we    (free_we),
    .waddr (free_waddr),
    .wdata (free_wdata),
    .re    (cmd.free_rd),
    .raddr (free_head),
    .rdata (free_q)
  );

  // Pending read address select
  always_comb begin
    case (cmd.pend_mode)
      RD_HEAD:  pend_raddr = pend_head;
      RD_LAST:  pend_raddr = slot(pend_head, pend_occ - CNT_W'(1));
      RD_DRAIN: pend_raddr = slot(pend_head, k);
      default:  pend_raddr = pend_head;
    endcase
  end

  assign pend_waddr = slot(pend_head, pend_occ);

  fbpm_ram #(.WIDTH(IDX_W), .DEPTH(POOL_MAX)) u_pend_ram (
    .clk   (clk),
    .we    (cmd.pend_push),
    .waddr (pend_waddr),
    .wdata (idx_q),
    .re    (cmd.pend_rd),
    .raddr (pend_raddr),
    .rdata (pend_q)
  );

  // Pointers, occupancies, drop counter, written marks
  always_ff @(posedge clk) begin
    if (rst) begin
      free_head <= '0;
      free_occ  <= eff_count(CNT_W'(POOL_COUNT_RESET), POOL_MAX);
      pend_head <= '0;
      pend_occ  <= '0;
      drop_cnt  <= '0;
      k         <= '0;
      for (int i = 0; i < POOL_MAX; i++) begin
        free_valid[i] <= 1'b0;
      end
    end else if (reinit) begin
      free_head <= '0;
      free_occ  <= eff_count(init_count, POOL_MAX);
      pend_head <= '0;
      pend_occ  <= '0;
      for (int i = 0; i < POOL_MAX; i++) begin
        free_valid[i] <= 1'b0;
      end
    end else begin
      if (cmd.latch) begin
        k <= '0;
      end
      if (cmd.drain_rd) begin
        k <= k + CNT_W'(1);
      end
      if (cmd.free_pop) begin
        free_head <= slot(free_head, CNT_W'(1));
        free_occ  <= free_occ - CNT_W'(1);
      end
      if (cmd.pend_pop) begin
        pend_head <= slot(pend_head, CNT_W'(1));
        pend_occ  <= pend_occ - CNT_W'(1);
        drop_cnt  <= drop_inc;
      end
      if (cmd.pend_push) begin
        pend_occ <= pend_occ + CNT_W'(1);
      end
      if (cmd.free_push_idx || (cmd.drain_push && drain_fits)) begin
        free_occ <= free_occ + CNT_W'(1);
      end
      // A dropped frame counts even when the free FIFO is full
      if (cmd.drain_push) begin
        drop_cnt <= drop_inc;
      end
      if (cmd.pend_clear) begin
        pend_head <= '0;
        pend_occ  <= '0;
      end
      if (free_we) begin
        free_valid[free_waddr] <= 1'b1;
      end
    end
  end

  // Item beat, grant and result registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q    <= opcode_t'(in_opcode);
      idx_q   <= in_index;
      granted <= '0;
    end
    if (cmd.free_rd) begin
      free_rd_valid <= free_valid[free_head];
      free_rd_dflt  <= IDX_W'(free_head);
    end
    if (cmd.free_pop) begin
      granted <= free_data;
    end
    if (cmd.pend_pop || cmd.grant_cons) begin
      granted <= pend_q;
    end
    if (cmd.load_out) begin
      status        <= cmd.status;
      granted_index <= (cmd.status == ST_OK) ? granted : '0;
      free_count    <= free_occ;
      dropped_total <= drop_cnt;
    end
  end

endmodule
